// ===== hdl/itg_pkg.sv =====
// Shared constants, codes and types of the interval timer group.
package itg_pkg;

   localparam int NUM_GROUPS_DEF  = 3;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int NUM_CHANS       = 3;

   localparam int GROUP_W  = 2;
   localparam int OFFSET_W = 2;
   localparam int DATA_W   = 8;

   localparam logic       FUNC_WRITE  = 1'b0;
   localparam logic       FUNC_TICK   = 1'b1;
   localparam logic [1:0] OFFSET_CTRL = 2'd3;

   localparam logic [1:0] LATCH_LOW  = 2'd1;
   localparam logic [1:0] LATCH_HIGH = 2'd2;
   localparam logic [1:0] LATCH_BOTH = 2'd3;

   localparam logic [2:0] CLK_MODE_ONESHOT = 3'd1;
   localparam logic [2:0] CLK_MODE_SQUARE  = 3'd3;

   typedef struct packed {
      logic       hold;
      logic [1:0] latch_mode;
      logic       latch_toggle;
      logic [2:0] clock_mode;
      logic       out_level;
      logic       prev_gate;
      logic       gate_level;
   } chan_ctl_type;

   localparam int CTL_W = $bits(chan_ctl_type);

   typedef struct packed {
      logic wr_ctrl;
      logic wr_count;
      logic tick;
      logic gate;
   } chan_op_type;

endpackage

// ===== hdl/itg_state_ram.sv =====
// Synchronous group state memory, one row per group, rows read as zero until written.
module itg_state_ram #(
   parameter int DEPTH = itg_pkg::NUM_GROUPS_DEF,
   parameter int WIDTH = 1,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   import itg_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hdl/itg_chan.sv =====
// Next-state logic of one counter channel for a control write, count write or tick.
module itg_chan #(
   parameter int COUNT_WIDTH = itg_pkg::COUNT_WIDTH_DEF
) (
   input  itg_pkg::chan_ctl_type         ctl_cur,
   input  logic [COUNT_WIDTH-1:0]        ic_cur,
   input  logic [COUNT_WIDTH-1:0]        rem_cur,
   input  itg_pkg::chan_op_type          op,
   input  logic [itg_pkg::DATA_W-1:0]    data,
   output itg_pkg::chan_ctl_type         ctl_nxt,
   output logic [COUNT_WIDTH-1:0]        ic_nxt,
   output logic [COUNT_WIDTH-1:0]        rem_nxt
);
   import itg_pkg::*;

   logic [15:0]            ic_wide;
   logic [COUNT_WIDTH-1:0] rem_dec;
   logic [COUNT_WIDTH-1:0] rem_sq;

   assign ic_wide = 16'(ic_cur);
   assign rem_dec = rem_cur - COUNT_WIDTH'(1);
   assign rem_sq  = {rem_dec[COUNT_WIDTH-1:1], 1'b0};

   always_comb begin
      ctl_nxt = ctl_cur;
      ic_nxt  = ic_cur;
      rem_nxt = rem_cur;
      if (op.wr_ctrl) begin
         ctl_nxt.hold         = 1'b1;
         ctl_nxt.latch_mode   = data[5:4];
         ctl_nxt.clock_mode   = data[3:1];
         ctl_nxt.latch_toggle = 1'b0;
         ctl_nxt.out_level    = (data[3:1] == CLK_MODE_ONESHOT);
      end else if (op.wr_count) begin
         case (ctl_cur.latch_mode)
            LATCH_LOW: begin
               ic_nxt       = COUNT_WIDTH'(data);
               ctl_nxt.hold = 1'b0;
            end
            LATCH_HIGH: begin
               ic_nxt       = COUNT_WIDTH'({data, 8'h00});
               ctl_nxt.hold = 1'b0;
            end
            LATCH_BOTH: begin
               if (!ctl_cur.latch_toggle) begin
                  ic_nxt               = COUNT_WIDTH'({ic_wide[15:8], data});
                  ctl_nxt.latch_toggle = 1'b1;
               end else begin
                  ic_nxt               = COUNT_WIDTH'({data, ic_wide[7:0]});
                  ctl_nxt.hold         = 1'b0;
                  ctl_nxt.latch_toggle = 1'b0;
               end
            end
            default: begin
            end
         endcase
         if (ctl_cur.hold && !ctl_nxt.hold) begin
            rem_nxt = COUNT_WIDTH'(1);
         end
      end else if (op.tick) begin
         ctl_nxt.prev_gate  = ctl_cur.gate_level;
         ctl_nxt.gate_level = op.gate;
         if (!ctl_cur.hold) begin
            case (ctl_cur.clock_mode)
               CLK_MODE_ONESHOT: begin
                  if (!ctl_cur.gate_level && op.gate) begin
                     ctl_nxt.out_level = 1'b0;
                     rem_nxt           = ic_cur;
                  end else begin
                     rem_nxt = rem_dec;
                     if (rem_dec == '0) begin
                        ctl_nxt.out_level = 1'b1;
                     end
                  end
               end
               CLK_MODE_SQUARE: begin
                  if (rem_sq == '0) begin
                     ctl_nxt.out_level = !ctl_cur.out_level;
                     rem_nxt           = ic_cur;
                  end else begin
                     rem_nxt = rem_sq;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ===== hdl/interval_timer_group_core.sv =====
// Top level of the interval timer group: transaction control around the group state memory.
//
// Usage:
//   req_* carries one transaction: a register write (req_func = 0) to a
//   control word (offset 3) or a count byte (offsets 0 to 2) of one group, or
//   a tick (req_func = 1) with per-channel clock enables and gate levels.
//   rsp_* returns one transaction per request: the three channel output
//   levels of the addressed group after the request has taken effect. A group
//   beyond the configured number changes nothing and returns zero.
// Timing:
//   The group's row is read from the state memory on acceptance, updated in
//   ST_EXEC and written back when the transaction finishes, which also loads
//   the response register. rsp_valid rises as ST_EXEC finishes; a new
//   request is taken only in ST_IDLE, after the read-modify-write of the
//   previous request's memory row is done.
// Reset:
//   All channels of every group read as zero after reset; no sweep is needed.
// Stall:
//   A waiting response does not block the next acceptance; the update of
//   that next transaction waits until the response register has been taken.
module interval_timer_group_core #(
   parameter int NUM_GROUPS  = itg_pkg::NUM_GROUPS_DEF,
   parameter int COUNT_WIDTH = itg_pkg::COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [itg_pkg::GROUP_W-1:0]      req_group,
   input  logic [itg_pkg::OFFSET_W-1:0]     req_offset,
   input  logic [itg_pkg::DATA_W-1:0]       req_data,
   input  logic [itg_pkg::NUM_CHANS-1:0]    req_clock_enables,
   input  logic [itg_pkg::NUM_CHANS-1:0]    req_gates,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [itg_pkg::NUM_CHANS-1:0]    rsp_channel_outputs
);
   import itg_pkg::*;

   localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int CH_W   = CTL_W + 2 * COUNT_WIDTH;
   localparam int ROW_W  = NUM_CHANS * CH_W;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUM_CHANS-1:0]    rsp_outputs_ff, rsp_outputs_in;
   logic                    func_ff;
   logic [OFFSET_W-1:0]     offset_ff;
   logic [DATA_W-1:0]       data_ff;
   logic [NUM_CHANS-1:0]    en_ff;
   logic [NUM_CHANS-1:0]    gates_ff;
   logic                    in_range_ff;
   logic [GIDX_W-1:0]       gidx_ff;

   logic                    accept;
   logic                    req_in_range;
   logic                    finish;
   logic [ROW_W-1:0]        rd_row;
   logic [ROW_W-1:0]        wr_row;
   logic [NUM_CHANS-1:0]    new_outputs;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = (32'(req_group) < NUM_GROUPS);
   assign finish       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   itg_state_ram #(
      .DEPTH (NUM_GROUPS),
      .WIDTH (ROW_W),
      .AW    (GIDX_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_in_range),
      .rd_addr (GIDX_W'(req_group)),
      .rd_data (rd_row),
      .wr_en   (finish && in_range_ff),
      .wr_addr (gidx_ff),
      .wr_data (wr_row)
   );

   for (genvar n = 0; n < NUM_CHANS; n++) begin : g_chan
      chan_ctl_type           ctl_cur, ctl_nxt;
      logic [COUNT_WIDTH-1:0] ic_nxt, rem_nxt;
      chan_op_type            op;

      assign ctl_cur     = chan_ctl_type'(rd_row[n*CH_W + 2*COUNT_WIDTH +: CTL_W]);
      assign op.wr_ctrl  = (func_ff == FUNC_WRITE) && (offset_ff == OFFSET_CTRL)
                           && (data_ff[7:6] == 2'(n));
      assign op.wr_count = (func_ff == FUNC_WRITE) && (offset_ff == 2'(n));
      assign op.tick     = (func_ff == FUNC_TICK) && en_ff[n];
      assign op.gate     = gates_ff[n];

      itg_chan #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_chan (
         .ctl_cur (ctl_cur),
         .ic_cur  (rd_row[n*CH_W + COUNT_WIDTH +: COUNT_WIDTH]),
         .rem_cur (rd_row[n*CH_W +: COUNT_WIDTH]),
         .op      (op),
         .data    (data_ff),
         .ctl_nxt (ctl_nxt),
         .ic_nxt  (ic_nxt),
         .rem_nxt (rem_nxt)
      );

      assign wr_row[n*CH_W +: CH_W] = {ctl_nxt, ic_nxt, rem_nxt};
      assign new_outputs[n]         = ctl_nxt.out_level;
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outputs_in = rsp_outputs_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_outputs_in = in_range_ff ? new_outputs : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_outputs_ff <= rsp_outputs_in;
      if (accept) begin
         func_ff     <= req_func;
         offset_ff   <= req_offset;
         data_ff     <= req_data;
         en_ff       <= req_clock_enables;
         gates_ff    <= req_gates;
         in_range_ff <= req_in_range;
         gidx_ff     <= GIDX_W'(req_group);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel_outputs = rsp_outputs_ff;

endmodule
